@@ hdl/tsa_pkg.sv @@
package tsa_pkg;

  localparam int TIMER_COUNT_DEFAULT = 8;
  localparam int MAX_TIMERS = 16;
  localparam int SLOT_W = 4;
  localparam int DIV_W = 20;

  localparam logic [DIV_W-1:0] US_PER_SECOND = 20'd1000000;
  localparam logic [DIV_W-1:0] US_PER_MS = 20'd1000;
  localparam logic [DIV_W-1:0] MAX_FREQUENCY_RESET = 20'd1000000;

  typedef enum logic [1:0] {
    OP_CLAIM   = 2'd0,
    OP_UNCLAIM = 2'd1,
    OP_START   = 2'd2,
    OP_CANCEL  = 2'd3
  } op_t;

  localparam logic [1:0] RATE_EXACT = 2'd0;
  localparam logic [1:0] RATE_OFF = 2'd1;
  localparam logic [1:0] RATE_FAILED = 2'd2;

endpackage

@@ hdl/tsa_div.sv @@
module tsa_div #(
  parameter int WIDTH = 20
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             done,
  output logic [WIDTH-1:0] quotient,
  output logic [WIDTH-1:0] remainder
);

  localparam int CNT_W = $clog2(WIDTH);

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [WIDTH-1:0] dvs;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;
  logic             ge;

  assign trial = {remainder, quotient[WIDTH-1]};
  assign diff = trial - {1'b0, dvs};
  assign ge = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == CNT_W'(WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      remainder <= '0;
      dvs <= divisor;
    end else if (busy) begin
      remainder <= ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
      quotient <= {quotient[WIDTH-2:0], ge};
    end
  end

endmodule

@@ hdl/timer_slot_allocator_period_calc.sv @@
// Timer slot allocator with repeat period calculation.
// The input channel (in_valid, in_stall) carries one request: claim, unclaim,
// start or cancel, with a timer index and a frequency in hertz. The output
// channel (out_valid, out_stall) returns exactly one result per request,
// with the outcome, the chosen slot, the period, the achieved frequency and
// both bitmaps after the request. The user must write max_frequency through
// cfg_write_en and cfg_write_data only while the block is idle; the block
// itself does not enforce this. A claim, unclaim, cancel or a start that
// fails its frequency check goes from transfer to the finish state and is
// then loaded. A start with a legal frequency first makes two passes of one
// shared 20-bit restoring divider, for the period and the achieved
// frequency, then finishes and is loaded. The millisecond period comes from
// a reciprocal multiplication while the second pass runs. One request is in
// work at a time; in_stall is high until the result is loaded.
// The result register holds its value while out_stall is high, and the next
// request may be transferred while it waits, but its result is not loaded
// until the previous one has been taken.
// Synchronous reset clears both bitmaps, restores max_frequency to 1000000
// and empties the output register.
module timer_slot_allocator_period_calc #(
  parameter int TIMER_COUNT = tsa_pkg::TIMER_COUNT_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [19:0] cfg_write_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [2:0]  timer_index,
  input  logic        index_valid,
  input  logic [19:0] frequency_hz,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        success,
  output logic [2:0]  chosen_index,
  output logic        chosen_valid,
  output logic [1:0]  rate_status,
  output logic        millisecond_scale,
  output logic [19:0] period_ticks,
  output logic [19:0] actual_frequency,
  output logic [7:0]  started_map,
  output logic [7:0]  claimed_map
);

  import tsa_pkg::*;

  localparam logic [MAX_TIMERS-1:0] SLOT_MASK =
    MAX_TIMERS'((33'(1) << TIMER_COUNT) - 33'(1));

  // Multiplying by ceil(2^30 / 1000) and dropping 30 bits gives the exact
  // quotient by 1000 for every 20-bit period.
  localparam logic [20:0] MS_RECIPROCAL = 21'd1073742;

  typedef enum logic [3:0] {
    S_IDLE     = 4'b0001,
    S_DIV_RATE = 4'b0010,
    S_DIV_ACT  = 4'b0100,
    S_FINISH   = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic [DIV_W-1:0]       max_frequency;
  logic [TIMER_COUNT-1:0] started_bits;
  logic [TIMER_COUNT-1:0] claimed_bits;

  op_t              op;
  logic [2:0]       idx;
  logic             idx_ok;
  logic             freq_ok;
  logic [DIV_W-1:0] per_us;
  logic [DIV_W-1:0] actual_us;
  logic [DIV_W-1:0] ms_ticks;
  logic             rate_off;
  logic             ms_exact;
  logic [40:0]      ms_prod;

  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  logic [DIV_W-1:0] div_divisor;
  logic             div_done;
  logic [DIV_W-1:0] div_quotient;
  logic [DIV_W-1:0] div_remainder;

  logic                  accept;
  logic                  load;
  logic [MAX_TIMERS-1:0] started_pad;
  logic [MAX_TIMERS-1:0] claimed_pad;
  logic [MAX_TIMERS-1:0] avail;
  logic [SLOT_W-1:0]     free_idx;
  logic                  free_ok;
  logic [SLOT_W-1:0]     idx_wide;
  logic                  usable;
  logic [SLOT_W-1:0]     pick;
  logic                  pick_ok;
  logic                  use_ms;

  logic                  res_success;
  logic [SLOT_W-1:0]     res_chosen;
  logic                  res_chosen_valid;
  logic [1:0]            res_rate;
  logic                  res_ms;
  logic [DIV_W-1:0]      res_ticks;
  logic [DIV_W-1:0]      res_actual;
  logic [MAX_TIMERS-1:0] started_pad_next;
  logic [MAX_TIMERS-1:0] claimed_pad_next;

  tsa_div #(
    .WIDTH(DIV_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient),
    .remainder(div_remainder)
  );

  assign in_stall = state != S_IDLE;
  assign accept = in_valid && !in_stall;
  assign load = (state == S_FINISH) && (!out_valid || !out_stall);
  assign ms_prod = per_us * MS_RECIPROCAL;

  always_comb begin
    state_next = state;
    div_start = 1'b0;
    div_dividend = US_PER_SECOND;
    div_divisor = frequency_hz;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (op_t'(operation) == OP_START && frequency_hz != '0 &&
              frequency_hz <= max_frequency && frequency_hz <= US_PER_SECOND) begin
            div_start = 1'b1;
            state_next = S_DIV_RATE;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_DIV_RATE: begin
        div_divisor = div_quotient;
        if (div_done) begin
          div_start = 1'b1;
          state_next = S_DIV_ACT;
        end
      end
      S_DIV_ACT: begin
        if (div_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op <= op_t'(operation);
      idx <= timer_index;
      idx_ok <= index_valid;
      freq_ok <= frequency_hz != '0 && frequency_hz <= max_frequency &&
                 frequency_hz <= US_PER_SECOND;
    end
    if (state == S_DIV_RATE && div_done) begin
      per_us <= div_quotient;
      rate_off <= div_remainder != '0;
    end
    if (state == S_DIV_ACT) begin
      ms_ticks <= {9'd0, ms_prod[40:30]};
    end
    if (state == S_DIV_ACT && div_done) begin
      actual_us <= div_quotient;
      ms_exact <= (ms_ticks * US_PER_MS) == per_us;
    end
  end

  always_comb begin
    started_pad = MAX_TIMERS'(started_bits);
    claimed_pad = MAX_TIMERS'(claimed_bits);
    avail = ~started_pad & ~claimed_pad & SLOT_MASK;
    free_idx = '0;
    free_ok = 1'b0;
    for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
      if (avail[i]) begin
        free_idx = SLOT_W'(i);
        free_ok = 1'b1;
      end
    end
    idx_wide = SLOT_W'(idx);
    usable = idx_ok && (32'(idx) < TIMER_COUNT);
    if (!usable || (!claimed_pad[idx_wide] && started_pad[idx_wide])) begin
      pick = free_idx;
      pick_ok = free_ok;
    end else begin
      pick = idx_wide;
      pick_ok = 1'b1;
    end
    use_ms = !rate_off && ms_exact;

    res_success = 1'b0;
    res_chosen = '0;
    res_chosen_valid = 1'b0;
    res_rate = RATE_EXACT;
    res_ms = 1'b0;
    res_ticks = '0;
    res_actual = '0;
    started_pad_next = started_pad;
    claimed_pad_next = claimed_pad;
    case (op)
      OP_CLAIM: begin
        if (free_ok) begin
          claimed_pad_next[free_idx] = 1'b1;
          res_success = 1'b1;
          res_chosen = free_idx;
          res_chosen_valid = 1'b1;
        end
      end
      OP_UNCLAIM: begin
        if (usable && claimed_pad[idx_wide]) begin
          claimed_pad_next[idx_wide] = 1'b0;
          res_success = 1'b1;
        end
      end
      OP_CANCEL: begin
        if (usable && started_pad[idx_wide]) begin
          started_pad_next[idx_wide] = 1'b0;
          res_success = 1'b1;
        end
      end
      OP_START: begin
        res_rate = RATE_FAILED;
        if (freq_ok && pick_ok && !started_pad[pick]) begin
          started_pad_next[pick] = 1'b1;
          res_success = 1'b1;
          res_chosen = pick;
          res_chosen_valid = 1'b1;
          res_rate = rate_off ? RATE_OFF : RATE_EXACT;
          res_ms = use_ms;
          res_ticks = use_ms ? ms_ticks : per_us;
          res_actual = actual_us;
        end
      end
      default: begin
        res_rate = RATE_EXACT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      max_frequency <= MAX_FREQUENCY_RESET;
      started_bits <= '0;
      claimed_bits <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write_en) begin
        max_frequency <= cfg_write_data;
      end
      if (load) begin
        started_bits <= started_pad_next[TIMER_COUNT-1:0];
        claimed_bits <= claimed_pad_next[TIMER_COUNT-1:0];
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      success <= res_success;
      chosen_index <= res_chosen[2:0];
      chosen_valid <= res_chosen_valid;
      rate_status <= res_rate;
      millisecond_scale <= res_ms;
      period_ticks <= res_ticks;
      actual_frequency <= res_actual;
      started_map <= started_pad_next[7:0];
      claimed_map <= claimed_pad_next[7:0];
    end
  end

  a_maps_change_on_load: assert property (@(posedge clk) disable iff (rst)
    (state != S_FINISH) |=> ($stable(started_bits) && $stable(claimed_bits)))
    else $error("Timer bitmaps changed outside the result load.");

  a_div_done_in_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV_RATE || state == S_DIV_ACT))
    else $error("Divider finished while no division was expected.");

  a_finish_loads_empty_output: assert property (@(posedge clk) disable iff (rst)
    ((state == S_FINISH) && !out_valid) |=> (out_valid && state == S_IDLE))
    else $error("Finished request was not loaded into an empty output register.");

  a_ms_scale_needs_success: assert property (@(posedge clk) disable iff (rst)
    (out_valid && millisecond_scale) |-> (success && rate_status == RATE_EXACT))
    else $error("Millisecond scale reported for an inexact or failed start.");

endmodule

@@ tb/sv/tb.sv @@
module tb;
  import tsa_pkg::*;

  localparam int SLOTS = TIMER_COUNT_DEFAULT;
  localparam int SEGMENTS = 6;
  localparam int SEGMENT_ITEMS = 235;

  typedef struct packed {
    op_t         operation;
    logic [2:0]  timer_index;
    logic        index_valid;
    logic [19:0] frequency_hz;
  } request_t;

  typedef struct packed {
    logic        success;
    logic [2:0]  chosen_index;
    logic        chosen_valid;
    logic [1:0]  rate_status;
    logic        millisecond_scale;
    logic [19:0] period_ticks;
    logic [19:0] actual_frequency;
    logic [7:0]  started_map;
    logic [7:0]  claimed_map;
  } outcome_t;

  typedef struct packed {
    request_t req;
    logic     typed;
    outcome_t want;
  } step_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_en = 1'b0;
  logic [19:0] cfg_write_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  operation = '0;
  logic [2:0]  timer_index = '0;
  logic        index_valid = 1'b0;
  logic [19:0] frequency_hz = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        success;
  logic [2:0]  chosen_index;
  logic        chosen_valid;
  logic [1:0]  rate_status;
  logic        millisecond_scale;
  logic [19:0] period_ticks;
  logic [19:0] actual_frequency;
  logic [7:0]  started_map;
  logic [7:0]  claimed_map;

  logic [7:0]  started_now = '0;
  logic [7:0]  claimed_now = '0;
  int unsigned max_hz = MAX_FREQUENCY_RESET;

  outcome_t    pending_outcomes[$];
  step_t       directed_steps[$];

  int          errors = 0;
  int          transfers = 0;
  int          results_checked = 0;
  int          starts_granted = 0;
  int          starts_ms = 0;
  int          starts_off = 0;
  int          settings_used = 1;
  int          send_gap_pct = 21;
  int          recv_stall_pct = 47;

  timer_slot_allocator_period_calc dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_write_en      (cfg_write_en),
    .cfg_write_data    (cfg_write_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .operation         (operation),
    .timer_index       (timer_index),
    .index_valid       (index_valid),
    .frequency_hz      (frequency_hz),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .success           (success),
    .chosen_index      (chosen_index),
    .chosen_valid      (chosen_valid),
    .rate_status       (rate_status),
    .millisecond_scale (millisecond_scale),
    .period_ticks      (period_ticks),
    .actual_frequency  (actual_frequency),
    .started_map       (started_map),
    .claimed_map       (claimed_map)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic request_t rq(op_t op, int idx, bit ok, int unsigned hz);
    request_t r;
    r.operation = op;
    r.timer_index = idx[2:0];
    r.index_valid = ok;
    r.frequency_hz = hz[19:0];
    return r;
  endfunction

  function automatic outcome_t oc(bit ok, int idx, bit idx_ok, logic [1:0] rate, bit ms,
                                  int unsigned ticks, int unsigned hz, logic [7:0] started,
                                  logic [7:0] claimed);
    outcome_t o;
    o.success = ok;
    o.chosen_index = idx[2:0];
    o.chosen_valid = idx_ok;
    o.rate_status = rate;
    o.millisecond_scale = ms;
    o.period_ticks = ticks[19:0];
    o.actual_frequency = hz[19:0];
    o.started_map = started;
    o.claimed_map = claimed;
    return o;
  endfunction

  function automatic int unsigned lowest_free_slot();
    for (int i = 0; i < SLOTS; i++) begin
      if (!started_now[i] && !claimed_now[i]) return i;
    end
    return SLOTS;
  endfunction

  function automatic outcome_t resolve_request(request_t r);
    outcome_t    o;
    int unsigned slot;
    int unsigned hz;
    int unsigned per_us;
    int unsigned ticks;
    bit          off;
    o = '0;
    hz = r.frequency_hz;
    case (r.operation)
      OP_CLAIM: begin
        slot = lowest_free_slot();
        if (slot < SLOTS) begin
          claimed_now[slot] = 1'b1;
          o.success = 1'b1;
          o.chosen_index = slot[2:0];
          o.chosen_valid = 1'b1;
        end
      end
      OP_UNCLAIM: begin
        if (r.index_valid && claimed_now[r.timer_index]) begin
          claimed_now[r.timer_index] = 1'b0;
          o.success = 1'b1;
        end
      end
      OP_CANCEL: begin
        if (r.index_valid && started_now[r.timer_index]) begin
          started_now[r.timer_index] = 1'b0;
          o.success = 1'b1;
        end
      end
      default: begin
        o.rate_status = RATE_FAILED;
        if (hz != 0 && hz <= max_hz && hz <= US_PER_SECOND) begin
          off = (US_PER_SECOND % hz) != 0;
          per_us = US_PER_SECOND / hz;
          if (!r.index_valid ||
              (!claimed_now[r.timer_index] && started_now[r.timer_index])) begin
            slot = lowest_free_slot();
          end else begin
            slot = r.timer_index;
          end
          if (slot < SLOTS && !started_now[slot]) begin
            started_now[slot] = 1'b1;
            o.success = 1'b1;
            o.chosen_index = slot[2:0];
            o.chosen_valid = 1'b1;
            o.rate_status = off ? RATE_OFF : RATE_EXACT;
            if (!off && (per_us % US_PER_MS) == 0) begin
              ticks = per_us / US_PER_MS;
              o.millisecond_scale = 1'b1;
              o.period_ticks = ticks[19:0];
              o.actual_frequency = 20'(US_PER_SECOND / (ticks * US_PER_MS));
            end else begin
              o.period_ticks = per_us[19:0];
              o.actual_frequency = 20'(US_PER_SECOND / per_us);
            end
          end
        end
      end
    endcase
    o.started_map = started_now;
    o.claimed_map = claimed_now;
    return o;
  endfunction

  function automatic request_t random_request();
    request_t    r;
    int unsigned pick;
    int unsigned hz;
    int          near;
    pick = $urandom_range(0, 99);
    if (pick < 25) r.operation = OP_CLAIM;
    else if (pick < 45) r.operation = OP_UNCLAIM;
    else if (pick < 80) r.operation = OP_START;
    else r.operation = OP_CANCEL;
    r.timer_index = 3'($urandom_range(0, 7));
    r.index_valid = ($urandom_range(0, 7) != 0);
    case ($urandom_range(0, 5))
      0: hz = 0;
      1: begin
        hz = 1;
        repeat ($urandom_range(0, 6)) hz = hz * 2;
        repeat ($urandom_range(0, 6)) hz = hz * 5;
      end
      2: hz = $urandom_range(1, 2000);
      3: begin
        near = int'(max_hz) + int'($urandom_range(0, 4)) - 2;
        if (near < 0) near = 0;
        if (near > 1000000) near = 1000000;
        hz = near;
      end
      default: hz = $urandom_range(0, 1000000);
    endcase
    r.frequency_hz = hz[19:0];
    return r;
  endfunction

  task automatic add_step(request_t r, bit typed, outcome_t want);
    step_t s;
    s.req = r;
    s.typed = typed;
    s.want = want;
    directed_steps.push_back(s);
  endtask

  task automatic transfer(request_t r, bit typed, outcome_t want);
    outcome_t pred;
    if ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_gap_pct);
    end
    in_valid <= 1'b1;
    operation <= r.operation;
    timer_index <= r.timer_index;
    index_valid <= r.index_valid;
    frequency_hz <= r.frequency_hz;
    do @(posedge clk); while (in_stall);
    pred = resolve_request(r);
    pending_outcomes.push_back(typed ? want : pred);
    transfers++;
    if (r.operation == OP_START && pred.success) begin
      starts_granted++;
      if (pred.millisecond_scale) starts_ms++;
      if (pred.rate_status == RATE_OFF) starts_off++;
    end
  endtask

  task automatic drain(int settle);
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_max_frequency(int unsigned hz);
    drain(8);
    cfg_write_en <= 1'b1;
    cfg_write_data <= hz[19:0];
    @(posedge clk);
    cfg_write_en <= 1'b0;
    max_hz = hz;
    settings_used++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    outcome_t w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_outcomes.size() == 0) begin
        $error("Result transfer with no request outstanding.");
        errors++;
      end else begin
        w = pending_outcomes.pop_front();
        results_checked++;
        if (success !== w.success) begin
          $error("success: expected %0d, got %0d", w.success, success);
          errors++;
        end
        if (chosen_index !== w.chosen_index) begin
          $error("chosen_index: expected %0d, got %0d", w.chosen_index, chosen_index);
          errors++;
        end
        if (chosen_valid !== w.chosen_valid) begin
          $error("chosen_valid: expected %0d, got %0d", w.chosen_valid, chosen_valid);
          errors++;
        end
        if (rate_status !== w.rate_status) begin
          $error("rate_status: expected %0d, got %0d", w.rate_status, rate_status);
          errors++;
        end
        if (millisecond_scale !== w.millisecond_scale) begin
          $error("millisecond_scale: expected %0d, got %0d", w.millisecond_scale,
                 millisecond_scale);
          errors++;
        end
        if (period_ticks !== w.period_ticks) begin
          $error("period_ticks: expected %0d, got %0d", w.period_ticks, period_ticks);
          errors++;
        end
        if (actual_frequency !== w.actual_frequency) begin
          $error("actual_frequency: expected %0d, got %0d", w.actual_frequency,
                 actual_frequency);
          errors++;
        end
        if (started_map !== w.started_map) begin
          $error("started_map: expected 0x%02h, got 0x%02h", w.started_map, started_map);
          errors++;
        end
        if (claimed_map !== w.claimed_map) begin
          $error("claimed_map: expected 0x%02h, got 0x%02h", w.claimed_map, claimed_map);
          errors++;
        end
      end
    end
  end

  initial begin
    int unsigned limits[SEGMENTS];
    outcome_t    none;
    none = '0;
    limits[0] = 1;
    limits[1] = 1000000;
    limits[2] = $urandom_range(2, 999999);
    limits[3] = 1000;
    limits[4] = $urandom_range(2, 999999);
    limits[5] = 1000000;

    add_step(rq(OP_START, 0, 0, 0), 1, oc(0, 0, 0, RATE_FAILED, 0, 0, 0, 8'h00, 8'h00));
    add_step(rq(OP_UNCLAIM, 0, 1, 0), 1, oc(0, 0, 0, RATE_EXACT, 0, 0, 0, 8'h00, 8'h00));
    add_step(rq(OP_CANCEL, 7, 1, 0), 1, oc(0, 0, 0, RATE_EXACT, 0, 0, 0, 8'h00, 8'h00));
    add_step(rq(OP_CLAIM, 6, 0, 1000000), 1,
             oc(1, 0, 1, RATE_EXACT, 0, 0, 0, 8'h00, 8'h01));
    add_step(rq(OP_START, 0, 1, 1000000), 1,
             oc(1, 0, 1, RATE_EXACT, 0, 1, 1000000, 8'h01, 8'h01));
    add_step(rq(OP_START, 0, 1, 1), 1, oc(0, 0, 0, RATE_FAILED, 0, 0, 0, 8'h01, 8'h01));
    add_step(rq(OP_START, 5, 0, 1), 1, oc(1, 1, 1, RATE_EXACT, 1, 1000, 1, 8'h03, 8'h01));
    add_step(rq(OP_START, 1, 1, 1000), 0, none);
    add_step(rq(OP_START, 7, 1, 3), 0, none);
    add_step(rq(OP_START, 6, 1, 999999), 0, none);
    add_step(rq(OP_START, 3, 1, 349525), 0, none);
    add_step(rq(OP_START, 4, 1, 699050), 0, none);
    add_step(rq(OP_CANCEL, 1, 1, 0), 0, none);
    add_step(rq(OP_CANCEL, 1, 1, 0), 0, none);
    add_step(rq(OP_CANCEL, 0, 0, 0), 0, none);
    add_step(rq(OP_UNCLAIM, 0, 1, 0), 0, none);
    add_step(rq(OP_CLAIM, 0, 1, 0), 0, none);
    add_step(rq(OP_CLAIM, 0, 1, 0), 0, none);
    add_step(rq(OP_CLAIM, 0, 1, 0), 1, oc(0, 0, 0, RATE_EXACT, 0, 0, 0, 8'hDD, 8'h22));
    add_step(rq(OP_START, 5, 0, 50), 1, oc(0, 0, 0, RATE_FAILED, 0, 0, 0, 8'hDD, 8'h22));
    add_step(rq(OP_START, 5, 1, 50), 0, none);
    add_step(rq(OP_START, 4, 1, 2), 0, none);
    add_step(rq(OP_UNCLAIM, 7, 0, 0), 0, none);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_steps[i]) begin
      transfer(directed_steps[i].req, directed_steps[i].typed, directed_steps[i].want);
    end

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      write_max_frequency(limits[seg]);
      send_gap_pct = (seg < 2) ? 21 : (seg < 4) ? 47 : 0;
      recv_stall_pct = (seg < 2) ? 47 : (seg < 4) ? 21 : 0;
      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        if (seg == 2 && n == SEGMENT_ITEMS / 2) drain(0);
        transfer(random_request(), 0, none);
      end
    end

    drain(80);
    $display("Run covered %0d transfers and %0d checked results under %0d frequency limits.",
             transfers, results_checked, settings_used);
    $display("Granted starts: %0d, of which %0d on the millisecond scale and %0d slightly off.",
             starts_granted, starts_ms, starts_off);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
